[sv/fdts_pkg.sv]
// fdts_pkg: shared types and constants of the depth-tested diffuse shading unit
// no dependencies; used by fragment_depth_test_diffuse_shade_unit
`timescale 1ns / 1ps

package fdts_pkg;

  // screen and depth store geometry
  localparam int SCREEN_W = 512;
  localparam int SCREEN_H = 512;
  localparam int STORE_DEPTH = SCREEN_W * SCREEN_H;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int ZW = 16;

  // 4*pi in Q4.12
  localparam logic [15:0] FOUR_PI_Q12 = 16'd51472;

  // command codes
  localparam logic CMD_SHADE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_LIGHT_X = 3'd0;
  localparam logic [2:0] REG_LIGHT_Y = 3'd1;
  localparam logic [2:0] REG_LIGHT_Z = 3'd2;
  localparam logic [2:0] REG_LIGHT_PWR = 3'd3;
  localparam logic [2:0] REG_AMB_PWR = 3'd4;

  // configuration reset values
  localparam logic [15:0] RST_LIGHT_X = 16'h0000;
  localparam logic [15:0] RST_LIGHT_Y = 16'hF800;
  localparam logic [15:0] RST_LIGHT_Z = 16'hF4CD;
  localparam logic [15:0] RST_LIGHT_PWR = 16'd2816;
  localparam logic [15:0] RST_AMB_PWR = 16'd128;

  typedef struct packed {
    logic               command;
    logic [8:0]         screen_x;
    logic [8:0]         screen_y;
    logic [15:0]        inv_depth;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [29:0]        surface_rgb;
  } in_req_t;

  typedef struct packed {
    logic        written;
    logic [8:0]  out_x;
    logic [8:0]  out_y;
    logic [15:0] lit_red;
    logic [15:0] lit_green;
    logic [15:0] lit_blue;
  } out_res_t;

endpackage

[sv/fragment_depth_test_diffuse_shade_unit.sv]
// fragment_depth_test_diffuse_shade_unit: z-buffer test with point light diffuse shading
// depends on fdts_pkg and fdts_ram
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; exactly one result follows, shown
// for one cycle with out_strobe, and the receiver cannot stall it. After reset and after a
// clear command the depth store is swept one entry per cycle with busy high; a clear
// command then returns an all-zero result. A fragment that fails the depth test or lies
// off screen returns a zero result. A passing fragment facing away from the light skips
// the shared square-root unit (two 18-step roots) and the shared restoring divider (16
// and 32 steps), through which a lit one passes.
// Configuration writes are taken at any cycle with cfg_we high.
module fragment_depth_test_diffuse_shade_unit
  import fdts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_strobe,
  output out_res_t    out_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TEST, S_MAC, S_SQRT, S_COSMUL, S_DIVCHK, S_DIV,
    S_PWRMUL, S_DENMUL, S_BASE, S_SHADE
  } state_t;

  state_t state_r;

  // configuration
  logic signed [15:0] lpx_r, lpy_r, lpz_r;
  logic [15:0]        lpwr_r, amb_r;

  // request and depth store
  in_req_t            req_r;
  logic [ADDR_W-1:0]  addr_r, clr_cnt_r;
  logic               clr_cmd_r, on_screen_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [ZW-1:0]      mem_wdata, mem_rdata;
  logic               pass_c;

  // vector sums
  logic signed [16:0] dx_r, dy_r, dz_r;
  logic [3:0]         k_r;
  logic signed [16:0] mac_a, mac_b;
  logic signed [33:0] prod;
  logic [34:0]        dd_r;
  logic [31:0]        nn_r;
  logic signed [34:0] dot_r;

  // square root
  logic [35:0]        sq_v_r, sq_res_r, sq_bit_r, sq_trial;
  logic               sq_ge, sq_phase_r;
  logic [4:0]         sq_cnt_r;
  logic [16:0]        sd_r;
  logic [15:0]        sn_r;

  // divider
  logic [49:0]        dv_p_r, dv_den_r;
  logic [31:0]        dv_l_r, dv_q_r, dv_q_nxt;
  logic [50:0]        dv_p2;
  logic               dv_ge, dv_mode_r;
  logic [5:0]         dv_cnt_r;
  logic [16:0]        c_r;
  logic [32:0]        pc_r;
  logic [31:0]        dif_r;

  // shading
  logic [32:0]        base_r;
  logic [1:0]         ch_r;
  logic [9:0]         col;
  logic [42:0]        lit_prod;
  logic [15:0]        lit_sat;
  logic               out_valid_r;
  out_res_t           out_res_r;

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [8:0] x, input logic [8:0] y);
    pix_addr = ADDR_W'(y) * ADDR_W'(SCREEN_W) + ADDR_W'(x);
  endfunction

  assign busy = (state_r != S_IDLE);
  assign out_strobe = out_valid_r;
  assign out_res = out_res_r;

  fdts_ram #(.WIDTH(ZW), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // depth test and store port control
  assign pass_c = on_screen_r && (req_r.inv_depth > mem_rdata);

  always_comb begin
    mem_we = 1'b0;
    mem_addr = pix_addr(in_req.screen_x, in_req.screen_y);
    mem_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_cnt_r;
      end
      S_TEST: begin
        mem_we = pass_c;
        mem_addr = addr_r;
        mem_wdata = req_r.inv_depth;
      end
      default: ;
    endcase
  end

  // multiply-accumulate operand select
  always_comb begin
    case (k_r)
      4'd0: begin mac_a = dx_r; mac_b = dx_r; end
      4'd1: begin mac_a = dy_r; mac_b = dy_r; end
      4'd2: begin mac_a = dz_r; mac_b = dz_r; end
      4'd3: begin mac_a = 17'(req_r.normal_x); mac_b = 17'(req_r.normal_x); end
      4'd4: begin mac_a = 17'(req_r.normal_y); mac_b = 17'(req_r.normal_y); end
      4'd5: begin mac_a = 17'(req_r.normal_z); mac_b = 17'(req_r.normal_z); end
      4'd6: begin mac_a = 17'(req_r.normal_x); mac_b = dx_r; end
      4'd7: begin mac_a = 17'(req_r.normal_y); mac_b = dy_r; end
      default: begin mac_a = 17'(req_r.normal_z); mac_b = dz_r; end
    endcase
  end
  assign prod = 34'(mac_a) * 34'(mac_b);

  // square-root and divider steps
  assign sq_trial = sq_res_r + sq_bit_r;
  assign sq_ge = (sq_v_r >= sq_trial);
  assign dv_p2 = {dv_p_r, dv_l_r[31]};
  assign dv_ge = (dv_p2 >= {1'b0, dv_den_r});
  assign dv_q_nxt = {dv_q_r[30:0], dv_ge};

  // channel shading
  always_comb begin
    case (ch_r)
      2'd0: col = req_r.surface_rgb[29:20];
      2'd1: col = req_r.surface_rgb[19:10];
      default: col = req_r.surface_rgb[9:0];
    endcase
  end
  assign lit_prod = 43'(col) * 43'(base_r);
  assign lit_sat = (lit_prod[42:26] != '0) ? 16'hFFFF : lit_prod[25:10];

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_cnt_r <= '0;
      clr_cmd_r <= 1'b0;
      out_valid_r <= 1'b0;
      lpx_r <= RST_LIGHT_X;
      lpy_r <= RST_LIGHT_Y;
      lpz_r <= RST_LIGHT_Z;
      lpwr_r <= RST_LIGHT_PWR;
      amb_r <= RST_AMB_PWR;
    end else begin
      out_valid_r <= 1'b0;

      // configuration writes
      if (cfg_we) begin
        case (cfg_idx)
          REG_LIGHT_X: lpx_r <= cfg_wdata;
          REG_LIGHT_Y: lpy_r <= cfg_wdata;
          REG_LIGHT_Z: lpz_r <= cfg_wdata;
          REG_LIGHT_PWR: lpwr_r <= cfg_wdata;
          REG_AMB_PWR: amb_r <= cfg_wdata;
          default: ;
        endcase
      end

      case (state_r)
        // clearing sweep
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
            state_r <= S_IDLE;
            if (clr_cmd_r) begin
              out_valid_r <= 1'b1;
              out_res_r <= '0;
            end
            clr_cmd_r <= 1'b0;
          end
        end

        // take a request
        S_IDLE: begin
          if (start) begin
            req_r <= in_req;
            addr_r <= pix_addr(in_req.screen_x, in_req.screen_y);
            on_screen_r <= (int'(in_req.screen_x) < SCREEN_W) &&
                           (int'(in_req.screen_y) < SCREEN_H);
            dx_r <= 17'(lpx_r) - 17'(in_req.pos_x);
            dy_r <= 17'(lpy_r) - 17'(in_req.pos_y);
            dz_r <= 17'(lpz_r) - 17'(in_req.pos_z);
            dd_r <= '0;
            nn_r <= '0;
            dot_r <= '0;
            k_r <= '0;
            if (in_req.command == CMD_CLEAR) begin
              clr_cmd_r <= 1'b1;
              clr_cnt_r <= '0;
              state_r <= S_CLEAR;
            end else begin
              state_r <= S_TEST;
            end
          end
        end

        // compare with stored inverse depth
        S_TEST: begin
          if (pass_c) begin
            state_r <= S_MAC;
          end else begin
            out_valid_r <= 1'b1;
            out_res_r <= '0;
            state_r <= S_IDLE;
          end
        end

        // squared lengths and dot product
        S_MAC: begin
          k_r <= k_r + 1'b1;
          if (k_r < 4'd3) begin
            dd_r <= dd_r + {1'b0, prod};
          end else if (k_r < 4'd6) begin
            nn_r <= nn_r + prod[31:0];
          end else begin
            dot_r <= dot_r + {prod[33], prod};
          end
          if (k_r == 4'd8) begin
            dif_r <= '0;
            sq_v_r <= {1'b0, dd_r};
            sq_res_r <= '0;
            sq_bit_r <= 36'd1 << 34;
            sq_cnt_r <= '0;
            sq_phase_r <= 1'b0;
            state_r <= S_SQRT;
          end
        end

        // shared square root, distance first then normal
        S_SQRT: begin
          if (k_r == 4'd9) begin
            k_r <= '0;
            if (!(dot_r > 0 && dd_r != '0 && nn_r != '0)) begin
              state_r <= S_BASE;
            end
          end else begin
            if (sq_ge) begin
              sq_v_r <= sq_v_r - sq_trial;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
            sq_cnt_r <= sq_cnt_r + 1'b1;
            if (sq_cnt_r == 5'd17) begin
              if (!sq_phase_r) begin
                sd_r <= sq_ge ? 17'((sq_res_r >> 1) + sq_bit_r) : 17'(sq_res_r >> 1);
                sq_v_r <= {4'b0, nn_r};
                sq_res_r <= '0;
                sq_bit_r <= 36'd1 << 34;
                sq_cnt_r <= '0;
                sq_phase_r <= 1'b1;
              end else begin
                sn_r <= sq_ge ? 16'((sq_res_r >> 1) + sq_bit_r) : 16'(sq_res_r >> 1);
                state_r <= S_COSMUL;
              end
            end
          end
        end

        // cosine division setup
        S_COSMUL: begin
          dv_den_r <= 50'(33'(sn_r) * 33'(sd_r));
          dv_p_r <= 50'(dot_r[33:0]);
          dv_l_r <= '0;
          dv_q_r <= '0;
          dv_cnt_r <= 6'd16;
          dv_mode_r <= 1'b0;
          state_r <= S_DIVCHK;
        end

        // quotient overflow saturates
        S_DIVCHK: begin
          if (dv_p_r >= dv_den_r) begin
            if (!dv_mode_r) begin
              c_r <= 17'd65536;
              state_r <= S_PWRMUL;
            end else begin
              dif_r <= '1;
              state_r <= S_BASE;
            end
          end else begin
            state_r <= S_DIV;
          end
        end

        // shared restoring divider, one quotient bit per cycle
        S_DIV: begin
          dv_p_r <= dv_ge ? 50'(dv_p2 - {1'b0, dv_den_r}) : 50'(dv_p2);
          dv_l_r <= {dv_l_r[30:0], 1'b0};
          dv_q_r <= dv_q_nxt;
          dv_cnt_r <= dv_cnt_r - 1'b1;
          if (dv_cnt_r == 6'd1) begin
            if (!dv_mode_r) begin
              c_r <= {1'b0, dv_q_nxt[15:0]};
              state_r <= S_PWRMUL;
            end else begin
              dif_r <= dv_q_nxt;
              state_r <= S_BASE;
            end
          end
        end

        // light power times cosine
        S_PWRMUL: begin
          pc_r <= 33'(lpwr_r) * 33'(c_r);
          state_r <= S_DENMUL;
        end

        // falloff division setup
        S_DENMUL: begin
          dv_den_r <= 50'(FOUR_PI_Q12) * 50'(dd_r);
          dv_p_r <= 50'(pc_r[32:8]);
          dv_l_r <= {pc_r[7:0], 24'b0};
          dv_q_r <= '0;
          dv_cnt_r <= 6'd32;
          dv_mode_r <= 1'b1;
          state_r <= S_DIVCHK;
        end

        // diffuse plus ambient
        S_BASE: begin
          base_r <= 33'(dif_r) + 33'({amb_r, 4'b0});
          ch_r <= '0;
          state_r <= S_SHADE;
        end

        // one channel per cycle
        S_SHADE: begin
          ch_r <= ch_r + 1'b1;
          case (ch_r)
            2'd0: out_res_r.lit_red <= lit_sat;
            2'd1: out_res_r.lit_green <= lit_sat;
            default: begin
              out_res_r.lit_blue <= lit_sat;
              out_res_r.written <= 1'b1;
              out_res_r.out_x <= req_r.screen_x;
              out_res_r.out_y <= req_r.screen_y;
              out_valid_r <= 1'b1;
              state_r <= S_IDLE;
            end
          endcase
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/fdts_ram.sv]
// fdts_ram: generic single-port synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps

module fdts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, or read into the registered rdata
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule
